>>> hdl/ntscan_pkg.sv
// Package: widths, codes, character classes and result type for the numeric token scanner.
`timescale 1ns / 1ps

package ntscan_pkg;

  // Offsets and lengths count modulo MaxLen
  localparam int unsigned MaxLen = 4096;
  localparam int unsigned PosW   = $clog2(MaxLen);
  localparam int unsigned ChW    = 8;

  // Result queue geometry
  localparam int unsigned ResqDepth = 4;
  localparam int unsigned ResqPtrW  = $clog2(ResqDepth);
  localparam int unsigned ResqCntW  = $clog2(ResqDepth + 1);

  // Characters of interest
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChComma = 8'h2C;
  localparam logic [ChW-1:0] ChSemi  = 8'h3B;
  localparam logic [ChW-1:0] ChDot   = 8'h2E;
  localparam logic [ChW-1:0] ChExpLo = 8'h65;
  localparam logic [ChW-1:0] ChExpUp = 8'h45;

  // Result kinds
  typedef enum logic [1:0] {
    KindValue = 2'd0,
    KindStop  = 2'd1,
    KindEnd   = 2'd2
  } kind_e;

  // Scan state, one-hot
  typedef enum logic [8:0] {
    ModeSearch  = 9'b0_0000_0001,
    ModeSign    = 9'b0_0000_0010,
    ModeInt     = 9'b0_0000_0100,
    ModeSep     = 9'b0_0000_1000,
    ModeFrac    = 9'b0_0001_0000,
    ModeExp     = 9'b0_0010_0000,
    ModeExpSign = 9'b0_0100_0000,
    ModeExpDig  = 9'b0_1000_0000,
    ModeStopped = 9'b1_0000_0000
  } mode_e;

  // One result item
  typedef struct packed {
    kind_e           kind;
    logic [PosW-1:0] token_start;
    logic [PosW-1:0] token_length;
    logic            final_res;
  } res_t;

  // Results produced by one byte transfer
  typedef struct packed {
    logic [1:0]       count;
    res_t [1:0]       data;
  } push_t;

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_sign(input logic [ChW-1:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

  function automatic logic is_sep(input logic [ChW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChComma) || (c == ChSemi);
  endfunction

  function automatic logic is_dec(input logic [ChW-1:0] c);
    return (c == ChComma) || (c == ChDot);
  endfunction

  function automatic logic is_exp(input logic [ChW-1:0] c);
    return (c == ChExpLo) || (c == ChExpUp);
  endfunction

endpackage

>>> hdl/ntscan_if.sv
// Interfaces: byte input channel and result output channel with valid/ready handshake.
`timescale 1ns / 1ps

interface ntscan_in_if;
  import ntscan_pkg::*;

  logic           valid;
  logic           ready;
  logic [ChW-1:0] ch;
  logic           last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ntscan_out_if;
  import ntscan_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [PosW-1:0] token_start;
  logic [PosW-1:0] token_length;
  logic            final_res;

  modport source (output valid, output kind, output token_start, output token_length,
                  output final_res, input ready);
  modport sink   (input valid, input kind, input token_start, input token_length,
                  input final_res, output ready);
endinterface

>>> hdl/ntscan_resq.sv
// Result queue: takes up to two results per cycle and hands them out one per transfer.
`timescale 1ns / 1ps

module ntscan_resq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ntscan_pkg::push_t         push_i,
  output logic                      room2_o,
  ntscan_out_if.source              out_o
);
  import ntscan_pkg::*;

  res_t                entry_q [ResqDepth];
  logic [ResqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResqCntW-1:0] cnt_q, cnt_d;
  logic [ResqPtrW-1:0] wr_ptr_p1;
  logic                pop;
  res_t                head;

  assign pop       = out_o.valid && out_o.ready;
  assign wr_ptr_p1 = wr_ptr_q + ResqPtrW'(1);
  assign room2_o   = cnt_q <= ResqCntW'(ResqDepth - 2);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + ResqPtrW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + ResqPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + ResqCntW'(push_i.count) - ResqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the results of this cycle in order
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.data[0];
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_ptr_p1] <= push_i.data[1];
    end
  end

  // Present the oldest result
  assign head               = entry_q[rd_ptr_q];
  assign out_o.valid        = cnt_q != '0;
  assign out_o.kind         = head.kind;
  assign out_o.token_start  = head.token_start;
  assign out_o.token_length = head.token_length;
  assign out_o.final_res    = head.final_res;

endmodule

>>> hdl/numeric_token_scanner_core.sv
// Top level: numeric token scanner, byte classification state machine and result queue.
// A result is registered in the result queue by the byte transfer that causes it.
// Throughput: one byte per cycle while the result queue has room for two more results;
// results leave at one per cycle while the output is ready, one result per transfer.
// Reset (rst_ni low, asynchronous): scan state returns to searching at offset zero with the
// first byte treated as a start point, and the result queue empties.
`timescale 1ns / 1ps

module numeric_token_scanner_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ntscan_in_if.sink    in_i,
  ntscan_out_if.source out_o
);
  import ntscan_pkg::*;

  mode_e           mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] vstart_q, vstart_d;
  logic [PosW-1:0] cend_q, cend_d;
  logic            prev_sep_q, prev_sep_d;
  logic            resume_q, resume_d;

  logic            room2;
  logic            take;
  push_t           push;

  assign in_i.ready = room2;
  assign take       = in_i.valid && in_i.ready;

  // Classify the byte and work out next state and results
  always_comb begin
    logic [ChW-1:0]  c;
    logic [PosW-1:0] pos_p1;
    logic            dig;
    logic            do_search;
    logic            srch_resume;
    logic            early_tok;
    logic            early_stop;
    logic            late_b;
    logic            late_c;
    mode_e           mode_n;
    logic [PosW-1:0] vstart_n;
    logic [PosW-1:0] cend_n;
    res_t            ra;
    res_t            rb;
    res_t            rc;

    c           = in_i.ch;
    pos_p1      = pos_q + PosW'(1);
    dig         = is_digit(c);
    do_search   = 1'b0;
    srch_resume = 1'b0;
    early_tok   = 1'b0;
    early_stop  = 1'b0;
    mode_n      = mode_q;
    vstart_n    = vstart_q;
    cend_n      = cend_q;

    unique case (mode_q)
      ModeSearch: begin
        do_search   = 1'b1;
        srch_resume = resume_q;
      end
      ModeSign: begin
        if (dig) begin
          mode_n = ModeInt;
          cend_n = pos_p1;
        end else begin
          early_stop = 1'b1;
          mode_n     = ModeStopped;
        end
      end
      ModeInt: begin
        if (dig) begin
          cend_n = pos_p1;
        end else if (is_dec(c)) begin
          mode_n = ModeSep;
        end else begin
          early_tok   = 1'b1;
          do_search   = 1'b1;
          srch_resume = 1'b1;
        end
      end
      ModeSep: begin
        if (dig) begin
          mode_n = ModeFrac;
          cend_n = pos_p1;
        end else begin
          early_tok = 1'b1;
          do_search = 1'b1;
        end
      end
      ModeFrac: begin
        if (dig) begin
          cend_n = pos_p1;
        end else if (is_exp(c)) begin
          mode_n = ModeExp;
        end else begin
          early_tok   = 1'b1;
          do_search   = 1'b1;
          srch_resume = 1'b1;
        end
      end
      ModeExp: begin
        if (is_sign(c)) begin
          mode_n = ModeExpSign;
        end else if (dig) begin
          mode_n = ModeExpDig;
          cend_n = pos_p1;
        end else begin
          early_tok = 1'b1;
          do_search = 1'b1;
        end
      end
      ModeExpSign: begin
        if (dig) begin
          mode_n = ModeExpDig;
          cend_n = pos_p1;
        end else begin
          early_tok = 1'b1;
          do_search = 1'b1;
        end
      end
      ModeExpDig: begin
        if (dig) begin
          cend_n = pos_p1;
        end else begin
          early_tok   = 1'b1;
          do_search   = 1'b1;
          srch_resume = 1'b1;
        end
      end
      ModeStopped: begin
        mode_n = ModeStopped;
      end
      default: begin
        mode_n = ModeStopped;
      end
    endcase

    // Decide whether this byte opens a new value
    if (do_search) begin
      mode_n = ModeSearch;
      if ((is_sign(c) || dig) && (srch_resume || prev_sep_q)) begin
        vstart_n = pos_q;
        if (dig) begin
          mode_n = ModeInt;
          cend_n = pos_p1;
        end else begin
          mode_n = ModeSign;
        end
      end
    end

    // Value closed by this byte, or a stop result, measured before the new start
    ra.kind         = early_stop ? KindStop : KindValue;
    ra.token_start  = early_stop ? '0 : vstart_q;
    ra.token_length = early_stop ? '0 : cend_q - vstart_q;
    ra.final_res    = early_stop;

    // End of string handling
    late_b          = 1'b0;
    late_c          = 1'b0;
    rb.kind         = KindEnd;
    rb.token_start  = '0;
    rb.token_length = '0;
    rb.final_res    = 1'b1;
    rc.kind         = KindEnd;
    rc.token_start  = '0;
    rc.token_length = '0;
    rc.final_res    = 1'b1;
    if (in_i.last) begin
      priority if (mode_n == ModeSearch) begin
        late_b = 1'b1;
      end else if (mode_n == ModeSign) begin
        late_b  = 1'b1;
        rb.kind = KindStop;
      end else if (mode_n != ModeStopped) begin
        late_b          = 1'b1;
        late_c          = 1'b1;
        rb.kind         = KindValue;
        rb.token_start  = vstart_n;
        rb.token_length = cend_n - vstart_n;
        rb.final_res    = 1'b0;
      end else begin
        late_b = 1'b0;
      end
    end

    // Pack the results in order
    push.count   = take ? (2'(early_tok || early_stop) + 2'(late_b) + 2'(late_c)) : 2'd0;
    push.data[0] = (early_tok || early_stop) ? ra : rb;
    push.data[1] = (early_tok || early_stop) ? rb : rc;

    // Next state; the last byte returns everything to reset values
    if (in_i.last) begin
      mode_d     = ModeSearch;
      pos_d      = '0;
      vstart_d   = '0;
      cend_d     = '0;
      prev_sep_d = 1'b0;
      resume_d   = 1'b1;
    end else begin
      mode_d     = mode_n;
      pos_d      = pos_p1;
      vstart_d   = vstart_n;
      cend_d     = cend_n;
      prev_sep_d = is_sep(c);
      resume_d   = 1'b0;
    end
  end

  // Hold scan state between transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeSearch;
      pos_q      <= '0;
      vstart_q   <= '0;
      cend_q     <= '0;
      prev_sep_q <= 1'b0;
      resume_q   <= 1'b1;
    end else if (take) begin
      mode_q     <= mode_d;
      pos_q      <= pos_d;
      vstart_q   <= vstart_d;
      cend_q     <= cend_d;
      prev_sep_q <= prev_sep_d;
      resume_q   <= resume_d;
    end
  end

  ntscan_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .out_o   (out_o)
  );

endmodule

>>> tb/numeric_token_scanner_core_tb.sv
// Testbench for the numeric token scanner: scoreboard against a byte-level scan predictor.
`timescale 1ns / 1ps

module numeric_token_scanner_core_tb;
  import ntscan_pkg::*;

  localparam int unsigned DrainLimit = 20000;

  logic clk;
  logic rst_n;

  ntscan_in_if  in_if ();
  ntscan_out_if out_if ();

  numeric_token_scanner_core i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // Scan predictor state
  mode_e           scan_mode_q;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] start_q;
  logic [PosW-1:0] end_q;
  logic            prev_blank_q;
  logic            resume_q;

  res_t            pending_results[$];
  logic [ChW-1:0]  text_q[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_cycles;
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned results_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Character classes
  function automatic logic digit_ch(input logic [ChW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic sign_ch(input logic [ChW-1:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

  function automatic logic blank_ch(input logic [ChW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChComma) || (c == ChSemi);
  endfunction

  function automatic logic point_ch(input logic [ChW-1:0] c);
    return (c == ChComma) || (c == ChDot);
  endfunction

  function automatic logic exp_ch(input logic [ChW-1:0] c);
    return (c == ChExpLo) || (c == ChExpUp);
  endfunction

  function automatic void reset_scan();
    scan_mode_q  = ModeSearch;
    pos_q        = '0;
    start_q      = '0;
    end_q        = '0;
    prev_blank_q = 1'b0;
    resume_q     = 1'b1;
  endfunction

  function automatic void emit(input kind_e k, input logic [PosW-1:0] s,
                               input logic [PosW-1:0] n, input logic f);
    res_t r;
    r.kind         = k;
    r.token_start  = s;
    r.token_length = n;
    r.final_res    = f;
    pending_results.push_back(r);
  endfunction

  // Close the open value at its last committed digit
  function automatic void emit_value();
    emit(KindValue, start_q, end_q - start_q, 1'b0);
  endfunction

  // Open a value if this byte may start one here
  function automatic void try_start(input logic [ChW-1:0] c, input logic [PosW-1:0] p,
                                    input logic ok);
    scan_mode_q = ModeSearch;
    if ((sign_ch(c) || digit_ch(c)) && (ok || prev_blank_q)) begin
      start_q = p;
      if (digit_ch(c)) begin
        scan_mode_q = ModeInt;
        end_q       = p + 1'b1;
      end else begin
        scan_mode_q = ModeSign;
      end
    end
  endfunction

  // Advance the predictor by one accepted byte and queue the results it causes
  function automatic void scan_byte(input logic [ChW-1:0] c, input logic is_last);
    logic [PosW-1:0] p;
    p = pos_q;
    case (scan_mode_q)
      ModeSearch: try_start(c, p, resume_q);
      ModeSign: begin
        if (digit_ch(c)) begin
          scan_mode_q = ModeInt;
          end_q       = p + 1'b1;
        end else begin
          emit(KindStop, '0, '0, 1'b1);
          scan_mode_q = ModeStopped;
        end
      end
      ModeInt: begin
        if (digit_ch(c)) end_q = p + 1'b1;
        else if (point_ch(c)) scan_mode_q = ModeSep;
        else begin
          emit_value();
          try_start(c, p, 1'b1);
        end
      end
      ModeSep: begin
        if (digit_ch(c)) begin
          scan_mode_q = ModeFrac;
          end_q       = p + 1'b1;
        end else begin
          emit_value();
          try_start(c, p, 1'b0);
        end
      end
      ModeFrac: begin
        if (digit_ch(c)) end_q = p + 1'b1;
        else if (exp_ch(c)) scan_mode_q = ModeExp;
        else begin
          emit_value();
          try_start(c, p, 1'b1);
        end
      end
      ModeExp: begin
        if (sign_ch(c)) scan_mode_q = ModeExpSign;
        else if (digit_ch(c)) begin
          scan_mode_q = ModeExpDig;
          end_q       = p + 1'b1;
        end else begin
          emit_value();
          try_start(c, p, 1'b0);
        end
      end
      ModeExpSign: begin
        if (digit_ch(c)) begin
          scan_mode_q = ModeExpDig;
          end_q       = p + 1'b1;
        end else begin
          emit_value();
          try_start(c, p, 1'b0);
        end
      end
      ModeExpDig: begin
        if (digit_ch(c)) end_q = p + 1'b1;
        else begin
          emit_value();
          try_start(c, p, 1'b1);
        end
      end
      default: scan_mode_q = ModeStopped;
    endcase
    prev_blank_q = blank_ch(c);
    resume_q     = 1'b0;
    pos_q        = p + 1'b1;

    // Close out the string on its final byte
    if (is_last) begin
      if (scan_mode_q == ModeSearch) begin
        emit(KindEnd, '0, '0, 1'b1);
      end else if (scan_mode_q == ModeSign) begin
        emit(KindStop, '0, '0, 1'b1);
      end else if (scan_mode_q != ModeStopped) begin
        emit_value();
        emit(KindEnd, '0, '0, 1'b1);
      end
      reset_scan();
    end
  endfunction

  // Drive one byte; entered and left just after a falling edge
  task automatic send_byte(input logic [ChW-1:0] c, input logic is_last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    scan_byte(c, is_last);
    bytes_sent++;
    if (is_last) strings_sent++;
    @(negedge clk);
  endtask

  // Send the staged text as one string
  task automatic send_staged();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic send_text(input string s, input logic close_it);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], close_it && (i == s.len() - 1));
    end
  endtask

  // Hold the sender until every expected result has come out
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      fail_count++;
      $error("%0d expected results never arrived", pending_results.size());
      pending_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  // Output side: random stalls, plus a counted hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_result
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("unexpected result: kind %0d start %0d length %0d final %0b",
               out_if.kind, out_if.token_start, out_if.token_length, out_if.final_res);
      end else begin
        want = pending_results.pop_front();
        if (out_if.kind !== want.kind) begin
          fail_count++;
          $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
        end
        if (out_if.token_start !== want.token_start) begin
          fail_count++;
          $error("token_start: expected %0d, got %0d", want.token_start, out_if.token_start);
        end
        if (out_if.token_length !== want.token_length) begin
          fail_count++;
          $error("token_length: expected %0d, got %0d", want.token_length,
                 out_if.token_length);
        end
        if (out_if.final_res !== want.final_res) begin
          fail_count++;
          $error("final_res: expected %0b, got %0b", want.final_res, out_if.final_res);
        end
      end
    end
  end

  // Random text pieces
  function automatic logic [ChW-1:0] rand_digit();
    return ChZero + ChW'($urandom_range(9));
  endfunction

  function automatic logic [ChW-1:0] rand_sign();
    return $urandom_range(1) ? ChPlus : ChMinus;
  endfunction

  function automatic logic [ChW-1:0] rand_blank();
    case ($urandom_range(3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChComma;
      default: return ChSemi;
    endcase
  endfunction

  function automatic void add_digits(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(lo, hi)) text_q.push_back(rand_digit());
  endfunction

  function automatic void add_number();
    if ($urandom_range(2) == 0) text_q.push_back(rand_sign());
    add_digits(1, 4);
    if ($urandom_range(1)) begin
      text_q.push_back($urandom_range(1) ? ChDot : ChComma);
      add_digits(1, 3);
      if ($urandom_range(2) == 0) begin
        text_q.push_back($urandom_range(1) ? ChExpLo : ChExpUp);
        if ($urandom_range(1)) text_q.push_back(rand_sign());
        add_digits(1, 2);
      end
    end
  endfunction

  // Numbers cut short at each point where the grammar can break
  function automatic void add_broken();
    case ($urandom_range(4))
      0: text_q.push_back(rand_sign());
      1: begin
        add_digits(1, 2);
        text_q.push_back(ChDot);
      end
      2: begin
        add_digits(1, 2);
        text_q.push_back(ChComma);
        add_digits(1, 2);
        text_q.push_back(ChExpLo);
      end
      3: begin
        add_digits(1, 2);
        text_q.push_back(ChDot);
        add_digits(1, 2);
        text_q.push_back(ChExpUp);
        text_q.push_back(rand_sign());
      end
      default: begin
        add_digits(1, 3);
        text_q.push_back(exp_ch(ChExpLo) ? ChExpLo : ChExpUp);
        add_digits(1, 2);
      end
    endcase
  endfunction

  function automatic void build_random_text();
    int unsigned pick;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      if (pick < 65) add_number();
      else if (pick < 85) add_broken();
      else repeat ($urandom_range(1, 3)) text_q.push_back(ChW'($urandom_range(255)));
      // Separators: mostly one, sometimes two, sometimes none to hit resume points
      pick = $urandom_range(9);
      if (pick < 6) text_q.push_back(rand_blank());
      else if (pick < 8) begin
        text_q.push_back(rand_blank());
        text_q.push_back(rand_blank());
      end
    end
  endfunction

  // Short strings for each corner of the grammar
  task automatic test_edge_cases();
    send_text("+", 1'b1);               // lone sign at end of string
    send_text("-x", 1'b0);              // sign without digits stops the scan
    send_byte(8'hFF, 1'b1);             // ignored until the last byte
    send_text("7-3;1.,4", 1'b1);        // resume point and a decimal point followed by a separator
    send_text("\t3.25E+", 1'b1);        // string ends in a dangling exponent sign
    send_text("a1 2e5", 1'b1);          // value not after a separator, integer then exponent
    send_text("9", 1'b0);
    send_byte(8'h00, 1'b1);             // zero byte ends a value on the last byte
    drain();
  endtask

  // Block the output long enough that the result queue fills and the input stalls
  task automatic test_backpressure();
    tx_idle_pct    = 0;
    rx_hold_cycles = 80;
    send_text("1 2 3 4 5 6 7 8 9 0 11 22;-3.5e+2", 1'b1);
    tx_idle_pct = 33;
    drain();
  endtask

  task automatic test_random_text();
    int unsigned start_bytes;
    start_bytes = bytes_sent;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (bytes_sent - start_bytes < 390) begin
      // Idle-free stretch first, then random gaps on both sides
      if (bytes_sent - start_bytes >= 150) begin
        tx_idle_pct = 33;
        rx_idle_pct = 33;
      end
      build_random_text();
      if (text_q.size() == 0) text_q.push_back(rand_digit());
      send_staged();
      // Pause now and then until the output side has caught up
      if ($urandom_range(15) == 0) drain();
    end
    drain();
  endtask

  // Test sequence
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.ch       = '0;
    in_if.last     = 1'b0;
    tx_idle_pct    = 33;
    rx_idle_pct    = 33;
    rx_hold_cycles = 0;
    fail_count     = 0;
    bytes_sent     = 0;
    strings_sent   = 0;
    results_seen   = 0;
    reset_scan();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_edge_cases();
    test_backpressure();
    test_random_text();

    $display("Scanned %0d bytes in %0d strings and checked %0d results",
             bytes_sent, strings_sent, results_seen);
    $display("Covered grammar corners, output back-pressure and random text");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ntscan_pkg.sv
hdl/ntscan_if.sv
hdl/ntscan_resq.sv
hdl/numeric_token_scanner_core.sv
tb/numeric_token_scanner_core_tb.sv
